>>> src/thq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thq_pkg: shared types and constants of the terrain height query block
// Field widths, register codes, operation codes and the structs that travel
// between the front end, the job queue and the back end.
// ----------------------------------------------------------------------------
package thq_pkg;

	// Default values of the top level parameters.
	localparam int MAX_GRID_DIM = 512;
	localparam int HEIGHT_BITS  = 16;
	localparam int FRAC_BITS    = 8;

	// Depth of the job queue between front end and back end.
	localparam int QUEUE_DEPTH = 2;

	// Fixed field widths.
	localparam int DIM_REG_W = 10;
	localparam int SCALE_W   = 24;
	localparam int POS_W     = 24;
	localparam int INDEX_W   = 18;
	localparam int ENTRY_W   = 16;
	localparam int OUT_W     = 26;

	// Output saturation limits (26-bit signed range).
	localparam int OUT_MAX = 33554431;
	localparam int OUT_MIN = -33554432;

	// Register codes: word index on the configuration port.
	localparam logic [1:0] REG_GRID_COLS   = 2'd0;
	localparam logic [1:0] REG_GRID_ROWS   = 2'd1;
	localparam logic [1:0] REG_INV_SCALE_X = 2'd2;
	localparam logic [1:0] REG_INV_SCALE_Z = 2'd3;

	// Register reset values.
	localparam logic [DIM_REG_W-1:0] GRID_COLS_RST = 10'd512;
	localparam logic [DIM_REG_W-1:0] GRID_ROWS_RST = 10'd512;
	localparam logic [SCALE_W-1:0]   INV_SCALE_RST = 24'd32768;

	// Operation codes of an input word.
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// Configuration registers as seen by the datapath.
	typedef struct packed {
		logic [DIM_REG_W-1:0] grid_cols;
		logic [DIM_REG_W-1:0] grid_rows;
		logic [SCALE_W-1:0]   inv_scale_x;
		logic [SCALE_W-1:0]   inv_scale_z;
	} thq_cfg_t;

	// Classification of one job.
	typedef struct packed {
		logic query;
		logic wr_ok;
		logic clamped;
	} thq_flags_t;

	// Queue status.
	typedef struct packed {
		logic full;
		logic empty;
	} thq_qstat_t;

endpackage

>>> src/thq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thq_ram: generic single-port RAM
// One write or one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module thq_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

>>> src/thq_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thq_front: command intake and cell resolution
// Accepts one word, scales a query position onto the grid, resolves cell,
// fractions and triangle, and pushes a ready-made job into the queue.
// ----------------------------------------------------------------------------
module thq_front #(
	parameter int MAX_GRID_DIM = thq_pkg::MAX_GRID_DIM,
	parameter int HEIGHT_BITS  = thq_pkg::HEIGHT_BITS,
	parameter int FRAC_BITS    = thq_pkg::FRAC_BITS,
	localparam int ADDR_W      = $clog2(MAX_GRID_DIM * MAX_GRID_DIM)
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  thq_pkg::thq_cfg_t                    cfg,
	input  logic                                 start,
	output logic                                 busy,
	input  logic                                 operation,
	input  logic [thq_pkg::INDEX_W-1:0]          entry_index,
	input  logic signed [thq_pkg::ENTRY_W-1:0]   entry_height,
	input  logic signed [thq_pkg::POS_W-1:0]     pos_x,
	input  logic signed [thq_pkg::POS_W-1:0]     pos_z,
	input  thq_pkg::thq_qstat_t                  qstat,
	output logic                                 push,
	output thq_pkg::thq_flags_t                  flags,
	output logic [ADDR_W-1:0]                    addr_p,
	output logic [ADDR_W-1:0]                    addr_q,
	output logic [ADDR_W-1:0]                    addr_r,
	output logic [FRAC_BITS:0]                   weight_q,
	output logic [FRAC_BITS:0]                   weight_r,
	output logic [HEIGHT_BITS-1:0]               wdata
);

	localparam int DIM_W  = $clog2(MAX_GRID_DIM + 1);
	localparam int EW     = (DIM_W > thq_pkg::DIM_REG_W) ? DIM_W : thq_pkg::DIM_REG_W;
	localparam int PROD_W = 49;
	localparam int SH     = thq_pkg::SCALE_W - FRAC_BITS;
	localparam int CW     = 27 + FRAC_BITS;
	localparam int IW     = (ADDR_W + 1 > thq_pkg::INDEX_W + 1) ? ADDR_W + 1
	                                                           : thq_pkg::INDEX_W + 1;

	localparam logic [2:0] F_IDLE  = 3'd0;
	localparam logic [2:0] F_COORD = 3'd1;
	localparam logic [2:0] F_AXIS  = 3'd2;
	localparam logic [2:0] F_BASE  = 3'd3;
	localparam logic [2:0] F_PUSH  = 3'd4;

	typedef struct packed {
		logic [DIM_W-1:0]   cell_idx;
		logic [FRAC_BITS:0] frac;
		logic               clamped;
	} axis_t;

	// Grid size register saturated to the supported range.
	function automatic logic [DIM_W-1:0] eff_dim(input logic [thq_pkg::DIM_REG_W-1:0] r);
		logic [EW-1:0] e;
		logic [DIM_W-1:0] d;
		e = EW'(r);
		if (e < EW'(2)) begin
			d = DIM_W'(2);
		end else if (e > EW'(MAX_GRID_DIM)) begin
			d = DIM_W'(MAX_GRID_DIM);
		end else begin
			d = DIM_W'(e);
		end
		return d;
	endfunction

	// One axis: coordinate with FRAC_BITS fraction bits to cell and weight.
	function automatic axis_t resolve(input logic signed [CW-1:0] coord,
	                                  input logic [DIM_W-1:0] dim);
		logic signed [CW-1:0] last;
		axis_t r;
		last = signed'(CW'(dim - 1'b1)) <<< FRAC_BITS;
		r.clamped = 1'b0;
		if (coord < 0) begin
			r.cell_idx = '0;
			r.frac     = '0;
			r.clamped  = 1'b1;
		end else if (coord >= last) begin
			r.cell_idx = dim - DIM_W'(2);
			r.frac     = {1'b1, {FRAC_BITS{1'b0}}};
			r.clamped  = (coord > last);
		end else begin
			r.cell_idx = coord[FRAC_BITS +: DIM_W];
			r.frac     = {1'b0, coord[FRAC_BITS-1:0]};
		end
		return r;
	endfunction

	logic [2:0] state_q;

	logic                            op_s1;
	logic                            idx_ok_s1;
	logic [ADDR_W-1:0]               waddr_s1;
	logic [HEIGHT_BITS-1:0]          wdata_s1;
	logic signed [PROD_W-1:0]        prod_x_s1;
	logic signed [PROD_W-1:0]        prod_z_s1;
	logic [DIM_W-1:0]                cols_s1;
	logic [DIM_W-1:0]                rows_s1;

	logic signed [CW-1:0]            cx_s2;
	logic signed [CW-1:0]            cz_s2;

	axis_t                           ax_s3;
	axis_t                           az_s3;

	logic [ADDR_W-1:0]               rowbase_s4;
	logic [DIM_W-1:0]                col_s4;
	logic [FRAC_BITS:0]              wq_s4;
	logic [FRAC_BITS:0]              wr_s4;
	logic                            lower_s4;
	logic                            clamp_s4;

	logic                            accept;
	logic signed [CW-1:0]            center_x;
	logic signed [CW-1:0]            center_z;
	logic signed [PROD_W:0]          neg_z;
	axis_t                           ax;
	axis_t                           az;
	logic [2*DIM_W-1:0]              rowbase_full;
	logic [FRAC_BITS+1:0]            frac_sum;
	logic [FRAC_BITS:0]              one;
	logic [ADDR_W-1:0]               corner_a;
	logic [ADDR_W-1:0]               corner_b;
	logic [ADDR_W-1:0]               corner_c;
	logic [ADDR_W-1:0]               corner_d;

	assign accept = start && (state_q == F_IDLE);
	assign busy   = (state_q != F_IDLE);
	assign one    = {1'b1, {FRAC_BITS{1'b0}}};

	// Sequencer over the resolution steps.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (accept) begin
						state_q <= (operation == thq_pkg::OP_QUERY) ? F_COORD : F_PUSH;
					end
				end
				F_COORD: state_q <= F_AXIS;
				F_AXIS:  state_q <= F_BASE;
				F_BASE:  state_q <= F_PUSH;
				F_PUSH: begin
					if (!qstat.full) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	// Stage 1: capture the word and scale the position.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1     <= operation;
			idx_ok_s1 <= (IW'(entry_index) < IW'(MAX_GRID_DIM * MAX_GRID_DIM));
			waddr_s1  <= ADDR_W'(entry_index);
			wdata_s1  <= HEIGHT_BITS'(entry_height);
			prod_x_s1 <= pos_x * $signed({1'b0, cfg.inv_scale_x});
			prod_z_s1 <= pos_z * $signed({1'b0, cfg.inv_scale_z});
			cols_s1   <= eff_dim(cfg.grid_cols);
			rows_s1   <= eff_dim(cfg.grid_rows);
		end
	end

	// Stage 2: center on the grid and drop the extra fraction bits.
	always_comb begin
		center_x = signed'(CW'(cols_s1 - 1'b1)) <<< (FRAC_BITS - 1);
		center_z = signed'(CW'(rows_s1 - 1'b1)) <<< (FRAC_BITS - 1);
		neg_z    = -((PROD_W + 1)'(prod_z_s1));
	end

	always_ff @(posedge clk) begin
		if (state_q == F_COORD) begin
			cx_s2 <= center_x + CW'(prod_x_s1 >>> SH);
			cz_s2 <= center_z + CW'(neg_z >>> SH);
		end
	end

	// Stage 3: cell and fraction on each axis.
	assign ax = resolve(cx_s2, cols_s1);
	assign az = resolve(cz_s2, rows_s1);

	always_ff @(posedge clk) begin
		if (state_q == F_AXIS) begin
			ax_s3 <= ax;
			az_s3 <= az;
		end
	end

	// Stage 4: row base address, triangle choice and weights.
	always_comb begin
		rowbase_full = az_s3.cell_idx * cols_s1;
		frac_sum     = {1'b0, ax_s3.frac} + {1'b0, az_s3.frac};
	end

	always_ff @(posedge clk) begin
		if (state_q == F_BASE) begin
			rowbase_s4 <= rowbase_full[ADDR_W-1:0];
			col_s4     <= ax_s3.cell_idx;
			lower_s4   <= (frac_sum >= {1'b0, one});
			wq_s4      <= (frac_sum >= {1'b0, one}) ? one - ax_s3.frac : ax_s3.frac;
			wr_s4      <= (frac_sum >= {1'b0, one}) ? one - az_s3.frac : az_s3.frac;
			clamp_s4   <= ax_s3.clamped | az_s3.clamped;
		end
	end

	// Corner addresses; the lower-right triangle bases on the far corner.
	always_comb begin
		corner_a = rowbase_s4 + ADDR_W'(col_s4);
		corner_b = corner_a + ADDR_W'(1);
		corner_c = corner_a + ADDR_W'(cols_s1);
		corner_d = corner_c + ADDR_W'(1);
	end

	// Job handed to the queue.
	always_comb begin
		push          = (state_q == F_PUSH) && !qstat.full;
		flags.query   = (op_s1 == thq_pkg::OP_QUERY);
		flags.wr_ok   = idx_ok_s1;
		flags.clamped = clamp_s4;
		wdata         = wdata_s1;
		weight_q      = wq_s4;
		weight_r      = wr_s4;
		if (op_s1 == thq_pkg::OP_QUERY) begin
			addr_p = lower_s4 ? corner_d : corner_a;
			addr_q = lower_s4 ? corner_c : corner_b;
			addr_r = lower_s4 ? corner_b : corner_c;
		end else begin
			addr_p = waddr_s1;
			addr_q = waddr_s1;
			addr_r = waddr_s1;
		end
	end

endmodule

>>> src/thq_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thq_queue: short job queue
// Register-based FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module thq_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = thq_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic [WIDTH-1:0]    din,
	input  logic                pop,
	output logic [WIDTH-1:0]    dout,
	output thq_pkg::thq_qstat_t qstat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign qstat.full  = (count_q == (PTR_W + 1)'(DEPTH));
	assign qstat.empty = (count_q == '0);
	assign dout        = entries_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= din;
		end
	end

endmodule

>>> src/thq_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thq_back: table access and interpolation
// Takes jobs from the queue, writes table entries or reads three corners,
// blends them over the chosen triangle and emits the result word.
// ----------------------------------------------------------------------------
module thq_back #(
	parameter int MAX_GRID_DIM = thq_pkg::MAX_GRID_DIM,
	parameter int HEIGHT_BITS  = thq_pkg::HEIGHT_BITS,
	parameter int FRAC_BITS    = thq_pkg::FRAC_BITS,
	localparam int ADDR_W      = $clog2(MAX_GRID_DIM * MAX_GRID_DIM)
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  thq_pkg::thq_qstat_t                qstat,
	output logic                               pop,
	input  thq_pkg::thq_flags_t                flags,
	input  logic [ADDR_W-1:0]                  addr_p,
	input  logic [ADDR_W-1:0]                  addr_q,
	input  logic [ADDR_W-1:0]                  addr_r,
	input  logic [FRAC_BITS:0]                 weight_q,
	input  logic [FRAC_BITS:0]                 weight_r,
	input  logic [HEIGHT_BITS-1:0]             wdata,
	output logic                               result_valid,
	output logic signed [thq_pkg::OUT_W-1:0]   height,
	output logic                               clamped
);

	localparam int PW    = HEIGHT_BITS + FRAC_BITS + 3;
	localparam int SUM_W = HEIGHT_BITS + FRAC_BITS + 3;
	localparam int SHL   = (FRAC_BITS < 8) ? 8 - FRAC_BITS : 0;
	localparam int SHR   = (FRAC_BITS > 8) ? FRAC_BITS - 8 : 0;
	localparam int SC_W  = (SUM_W + SHL > 27) ? SUM_W + SHL : 27;

	localparam logic [2:0] B_IDLE = 3'd0;
	localparam logic [2:0] B_WR   = 3'd1;
	localparam logic [2:0] B_RD0  = 3'd2;
	localparam logic [2:0] B_RD1  = 3'd3;
	localparam logic [2:0] B_RD2  = 3'd4;
	localparam logic [2:0] B_RD3  = 3'd5;
	localparam logic [2:0] B_MUL  = 3'd6;
	localparam logic [2:0] B_SUM  = 3'd7;

	logic [2:0] state_q;
	logic       out_pending_q;

	thq_pkg::thq_flags_t          flags_q;
	logic [ADDR_W-1:0]            addr_p_q;
	logic [ADDR_W-1:0]            addr_q_q;
	logic [ADDR_W-1:0]            addr_r_q;
	logic [FRAC_BITS:0]           wq_q;
	logic [FRAC_BITS:0]           wr_q;
	logic [HEIGHT_BITS-1:0]       wdata_q;

	logic signed [HEIGHT_BITS-1:0] ht_p_q;
	logic signed [HEIGHT_BITS-1:0] ht_q_q;
	logic signed [HEIGHT_BITS-1:0] ht_r_q;
	logic signed [PW-1:0]          m1_q;
	logic signed [PW-1:0]          m2_q;
	logic signed [SUM_W-1:0]       sum_q;

	logic                          ram_we;
	logic [ADDR_W-1:0]             ram_addr;
	logic [HEIGHT_BITS-1:0]        ram_rdata;
	logic signed [HEIGHT_BITS:0]   diff_q;
	logic signed [HEIGHT_BITS:0]   diff_r;
	logic signed [SC_W-1:0]        scaled;
	logic signed [SC_W-1:0]        sat;

	assign pop = (state_q == B_IDLE) && !qstat.empty;

	// Job sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= B_IDLE;
			out_pending_q <= 1'b0;
			result_valid  <= 1'b0;
		end else begin
			result_valid  <= out_pending_q;
			out_pending_q <= (state_q == B_SUM);
			case (state_q)
				B_IDLE: begin
					if (pop) begin
						state_q <= flags.query ? B_RD0 : B_WR;
					end
				end
				B_WR:  state_q <= B_IDLE;
				B_RD0: state_q <= B_RD1;
				B_RD1: state_q <= B_RD2;
				B_RD2: state_q <= B_RD3;
				B_RD3: state_q <= B_MUL;
				B_MUL: state_q <= B_SUM;
				B_SUM: state_q <= B_IDLE;
				default: state_q <= B_IDLE;
			endcase
		end
	end

	// Job registers loaded from the queue head.
	always_ff @(posedge clk) begin
		if (pop) begin
			flags_q  <= flags;
			addr_p_q <= addr_p;
			addr_q_q <= addr_q;
			addr_r_q <= addr_r;
			wq_q     <= weight_q;
			wr_q     <= weight_r;
			wdata_q  <= wdata;
		end
	end

	// Table port: one write, or three reads in consecutive cycles.
	always_comb begin
		ram_we = (state_q == B_WR) && flags_q.wr_ok;
		case (state_q)
			B_RD1:   ram_addr = addr_q_q;
			B_RD2:   ram_addr = addr_r_q;
			default: ram_addr = addr_p_q;
		endcase
	end

	thq_ram #(
		.WIDTH(HEIGHT_BITS),
		.DEPTH(MAX_GRID_DIM * MAX_GRID_DIM)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (wdata_q),
		.rdata (ram_rdata)
	);

	// Capture each corner from the registered read data in the state after its address.
	always_ff @(posedge clk) begin
		if (state_q == B_RD1) begin
			ht_p_q <= ram_rdata;
		end
		if (state_q == B_RD2) begin
			ht_q_q <= ram_rdata;
		end
		if (state_q == B_RD3) begin
			ht_r_q <= ram_rdata;
		end
	end

	// Weighted corner differences.
	always_comb begin
		diff_q = (HEIGHT_BITS + 1)'(ht_q_q) - (HEIGHT_BITS + 1)'(ht_p_q);
		diff_r = (HEIGHT_BITS + 1)'(ht_r_q) - (HEIGHT_BITS + 1)'(ht_p_q);
	end

	always_ff @(posedge clk) begin
		if (state_q == B_MUL) begin
			m1_q <= diff_q * $signed({1'b0, wq_q});
			m2_q <= diff_r * $signed({1'b0, wr_q});
		end
		if (state_q == B_SUM) begin
			sum_q <= (SUM_W'(ht_p_q) <<< FRAC_BITS) + SUM_W'(m1_q) + SUM_W'(m2_q);
		end
	end

	// Bring the sum to 8 fraction bits and saturate.
	always_comb begin
		scaled = (SC_W'(sum_q) <<< SHL) >>> SHR;
		if (scaled > SC_W'(thq_pkg::OUT_MAX)) begin
			sat = SC_W'(thq_pkg::OUT_MAX);
		end else if (scaled < SC_W'(thq_pkg::OUT_MIN)) begin
			sat = SC_W'(thq_pkg::OUT_MIN);
		end else begin
			sat = scaled;
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (out_pending_q) begin
			height  <= sat[thq_pkg::OUT_W-1:0];
			clamped <= flags_q.clamped;
		end
	end

	// A job is taken only from a queue that holds one.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty)
		else $error("job taken from an empty queue");

	// A write job goes straight to the table write cycle.
	a_write_job: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !flags.query) |=> (state_q == B_WR))
		else $error("write job did not reach the table write cycle");

	// The result strobe follows the summing step.
	a_strobe_source: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(state_q == B_SUM, 2))
		else $error("result strobe without a finished query");

	// The strobe lasts one cycle.
	a_strobe_single: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result strobe longer than one cycle");

endmodule

>>> src/terrain_height_query.sv
`timescale 1ns / 1ps
// The back end sets the query rate and takes no new job until the last is done: job pickup,
// three corner reads on the single table port with a read drain state, then multiply and sum;
// a write job takes pickup and the table write. The front end is busy while it resolves a query
// or pushes a job, and longer while the queue is full; the receiver cannot stall. Reset clears
// the sequencers, the queue and the configuration registers; table entries stay undefined until
// written and there is no clearing pass.
// ----------------------------------------------------------------------------
// terrain_height_query: heightmap triangle interpolation
// Holds a grid of vertex heights and returns the interpolated height at a
// world position, with an APB-style register port for grid size and scale.
// ----------------------------------------------------------------------------
module terrain_height_query #(
	parameter int MAX_GRID_DIM = thq_pkg::MAX_GRID_DIM,
	parameter int HEIGHT_BITS  = thq_pkg::HEIGHT_BITS,
	parameter int FRAC_BITS    = thq_pkg::FRAC_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [3:0]                         paddr,
	input  logic [31:0]                        pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready,
	input  logic                               start,
	output logic                               busy,
	input  logic                               operation,
	input  logic [thq_pkg::INDEX_W-1:0]        entry_index,
	input  logic signed [thq_pkg::ENTRY_W-1:0] entry_height,
	input  logic signed [thq_pkg::POS_W-1:0]   pos_x,
	input  logic signed [thq_pkg::POS_W-1:0]   pos_z,
	output logic                               result_valid,
	output logic signed [thq_pkg::OUT_W-1:0]   height,
	output logic                               clamped
);

	localparam int ADDR_W = $clog2(MAX_GRID_DIM * MAX_GRID_DIM);
	localparam int JOB_W  = $bits(thq_pkg::thq_flags_t) + 3 * ADDR_W
	                      + 2 * (FRAC_BITS + 1) + HEIGHT_BITS;

	thq_pkg::thq_cfg_t   cfg_q;
	thq_pkg::thq_qstat_t qstat;

	logic                   push;
	logic                   pop;
	thq_pkg::thq_flags_t    f_flags;
	logic [ADDR_W-1:0]      f_addr_p;
	logic [ADDR_W-1:0]      f_addr_q;
	logic [ADDR_W-1:0]      f_addr_r;
	logic [FRAC_BITS:0]     f_weight_q;
	logic [FRAC_BITS:0]     f_weight_r;
	logic [HEIGHT_BITS-1:0] f_wdata;

	thq_pkg::thq_flags_t    b_flags;
	logic [ADDR_W-1:0]      b_addr_p;
	logic [ADDR_W-1:0]      b_addr_q;
	logic [ADDR_W-1:0]      b_addr_r;
	logic [FRAC_BITS:0]     b_weight_q;
	logic [FRAC_BITS:0]     b_weight_r;
	logic [HEIGHT_BITS-1:0] b_wdata;

	logic [JOB_W-1:0]       job_in;
	logic [JOB_W-1:0]       job_out;

	assign pready = 1'b1;

	// Configuration registers, written in the access cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.grid_cols   <= thq_pkg::GRID_COLS_RST;
			cfg_q.grid_rows   <= thq_pkg::GRID_ROWS_RST;
			cfg_q.inv_scale_x <= thq_pkg::INV_SCALE_RST;
			cfg_q.inv_scale_z <= thq_pkg::INV_SCALE_RST;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[3:2])
				thq_pkg::REG_GRID_COLS:   cfg_q.grid_cols   <= pwdata[thq_pkg::DIM_REG_W-1:0];
				thq_pkg::REG_GRID_ROWS:   cfg_q.grid_rows   <= pwdata[thq_pkg::DIM_REG_W-1:0];
				thq_pkg::REG_INV_SCALE_X: cfg_q.inv_scale_x <= pwdata[thq_pkg::SCALE_W-1:0];
				thq_pkg::REG_INV_SCALE_Z: cfg_q.inv_scale_z <= pwdata[thq_pkg::SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	// Register read back.
	always_comb begin
		case (paddr[3:2])
			thq_pkg::REG_GRID_COLS:   prdata = 32'(cfg_q.grid_cols);
			thq_pkg::REG_GRID_ROWS:   prdata = 32'(cfg_q.grid_rows);
			thq_pkg::REG_INV_SCALE_X: prdata = 32'(cfg_q.inv_scale_x);
			thq_pkg::REG_INV_SCALE_Z: prdata = 32'(cfg_q.inv_scale_z);
			default:                  prdata = '0;
		endcase
	end

	thq_front #(
		.MAX_GRID_DIM (MAX_GRID_DIM),
		.HEIGHT_BITS  (HEIGHT_BITS),
		.FRAC_BITS    (FRAC_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.start        (start),
		.busy         (busy),
		.operation    (operation),
		.entry_index  (entry_index),
		.entry_height (entry_height),
		.pos_x        (pos_x),
		.pos_z        (pos_z),
		.qstat        (qstat),
		.push         (push),
		.flags        (f_flags),
		.addr_p       (f_addr_p),
		.addr_q       (f_addr_q),
		.addr_r       (f_addr_r),
		.weight_q     (f_weight_q),
		.weight_r     (f_weight_r),
		.wdata        (f_wdata)
	);

	// Pack and unpack the job word around the queue.
	assign job_in = {f_flags, f_addr_p, f_addr_q, f_addr_r, f_weight_q, f_weight_r, f_wdata};
	assign {b_flags, b_addr_p, b_addr_q, b_addr_r, b_weight_q, b_weight_r, b_wdata} = job_out;

	thq_queue #(
		.WIDTH (JOB_W),
		.DEPTH (thq_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (job_in),
		.pop    (pop),
		.dout   (job_out),
		.qstat  (qstat)
	);

	thq_back #(
		.MAX_GRID_DIM (MAX_GRID_DIM),
		.HEIGHT_BITS  (HEIGHT_BITS),
		.FRAC_BITS    (FRAC_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.qstat        (qstat),
		.pop          (pop),
		.flags        (b_flags),
		.addr_p       (b_addr_p),
		.addr_q       (b_addr_q),
		.addr_r       (b_addr_r),
		.weight_q     (b_weight_q),
		.weight_r     (b_weight_r),
		.wdata        (b_wdata),
		.result_valid (result_valid),
		.height       (height),
		.clamped      (clamped)
	);

endmodule
